// File: hw/rtl/bumper_edge_and_wheel_click_accumulator_top_defines.svh
// Assertion helpers used by the checker file bewc_checker.sv.
`ifndef BUMPER_EDGE_AND_WHEEL_CLICK_ACCUMULATOR_TOP_DEFINES_SVH
`define BUMPER_EDGE_AND_WHEEL_CLICK_ACCUMULATOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BEWC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bewc check failed");

// Consequent must hold in the cycle after the antecedent.
`define BEWC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bewc check failed");

`endif

// File: hw/rtl/bewc_pkg.sv
package bewc_pkg;

  localparam logic [1:0]  KIND_LEFT   = 2'd0;
  localparam logic [1:0]  KIND_RIGHT  = 2'd1;
  localparam logic [1:0]  KIND_REPORT = 2'd2;

  localparam logic [2:0]  SWITCH_MASK  = 3'h7;
  localparam int unsigned SWITCH_RIGHT = 0;
  localparam int unsigned SWITCH_LEFT  = 1;

  localparam logic [15:0] REPORT_INTERVAL_RST = 16'd100;
  localparam int          QUEUE_DEPTH_DEF     = 4;

  // One queued job: which results an input caused, plus report payload.
  typedef struct packed {
    logic               ev_left;
    logic               ev_right;
    logic               report;
    logic signed [15:0] left_sum;
    logic signed [15:0] right_sum;
    logic [15:0]        span;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: hw/rtl/bewc_front.sv
module bewc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic [2:0]         in_switch_bits,
  input  logic signed [7:0]  in_left_delta,
  input  logic signed [7:0]  in_right_delta,
  input  logic [31:0]        in_packet_stamp,
  input  logic [31:0]        in_now_ticks,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_report_interval,
  input  bewc_pkg::q_stat_t  q_stat,
  output logic               q_push,
  output bewc_pkg::job_t     q_job
);
  import bewc_pkg::*;

  function automatic logic signed [15:0] sat_add(logic signed [15:0] acc,
                                                 logic signed [7:0] d);
    logic signed [16:0] s;
    s = {acc[15], acc} + {{9{d[7]}}, d};
    if (s[16] != s[15]) begin
      sat_add = s[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      sat_add = s[15:0];
    end
  endfunction

  logic [15:0]        interval_r;
  logic [2:0]         prev_sw_r;
  logic signed [15:0] left_acc_r;
  logic signed [15:0] right_acc_r;
  logic [31:0]        latest_r;
  logic [31:0]        start_r;
  logic [31:0]        deadline_r;
  logic               pending_r;

  logic               accept;
  logic [2:0]         cur_sw;
  logic [2:0]         rise;
  logic signed [15:0] left_pkt;
  logic signed [15:0] right_pkt;
  logic [31:0]        stamp_pkt;
  logic               pend_pkt;
  logic               report;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_stat.full;
  assign accept    = in_valid & ~in_stall;

  assign cur_sw    = in_switch_bits & SWITCH_MASK;
  assign rise      = ~prev_sw_r & cur_sw;
  assign left_pkt  = in_func ? sat_add(left_acc_r, in_left_delta) : left_acc_r;
  assign right_pkt = in_func ? sat_add(right_acc_r, in_right_delta) : right_acc_r;
  assign stamp_pkt = in_func ? in_packet_stamp : latest_r;
  assign pend_pkt  = in_func | pending_r;
  assign report    = pend_pkt & (in_now_ticks >= deadline_r);

  always_comb begin
    q_job.ev_left   = in_func & rise[SWITCH_LEFT];
    q_job.ev_right  = in_func & rise[SWITCH_RIGHT];
    q_job.report    = report;
    q_job.left_sum  = left_pkt;
    q_job.right_sum = right_pkt;
    q_job.span      = stamp_pkt[15:0] - start_r[15:0];
  end

  assign q_push = accept & (q_job.ev_left | q_job.ev_right | q_job.report);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= REPORT_INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      interval_r <= cfg_report_interval;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sw_r   <= '0;
      left_acc_r  <= '0;
      right_acc_r <= '0;
      latest_r    <= '0;
      start_r     <= '0;
      deadline_r  <= {16'd0, REPORT_INTERVAL_RST};
      pending_r   <= 1'b0;
    end else if (accept) begin
      if (in_func) begin
        prev_sw_r <= cur_sw;
      end
      latest_r <= stamp_pkt;
      if (report) begin
        // clear sums and open a new period
        left_acc_r  <= '0;
        right_acc_r <= '0;
        start_r     <= stamp_pkt;
        deadline_r  <= in_now_ticks + {16'd0, interval_r};
        pending_r   <= 1'b0;
      end else begin
        left_acc_r  <= left_pkt;
        right_acc_r <= right_pkt;
        pending_r   <= pend_pkt;
      end
    end
  end

endmodule

// File: hw/rtl/bewc_queue.sv
module bewc_queue #(
  parameter int DEPTH = bewc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bewc_pkg::job_t     push_job,
  input  logic               pop,
  output bewc_pkg::job_t     head_job,
  output bewc_pkg::q_stat_t  stat
);
  import bewc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & ~stat.empty;
  assign head_job   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/bewc_back.sv
module bewc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bewc_pkg::job_t     head_job,
  input  bewc_pkg::q_stat_t  q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic signed [15:0] out_left_sum,
  output logic signed [15:0] out_right_sum,
  output logic [15:0]        out_span_ticks,
  output logic               out_last
);
  import bewc_pkg::*;

  logic               valid_r;
  logic [1:0]         done_r;    // bit0 left sent, bit1 right sent
  logic [1:0]         kind_r;
  logic signed [15:0] lsum_r;
  logic signed [15:0] rsum_r;
  logic [15:0]        span_r;
  logic               last_r;

  logic               rem_left;
  logic               rem_right;
  logic               load;
  logic [1:0]         nxt_kind;
  logic               nxt_last;

  assign rem_left  = head_job.ev_left & ~done_r[0];
  assign rem_right = head_job.ev_right & ~done_r[1];
  assign load      = ~q_stat.empty & (~valid_r | ~out_stall);
  assign pop       = load & nxt_last;

  always_comb begin
    if (rem_left) begin
      nxt_kind = KIND_LEFT;
      nxt_last = ~(rem_right | head_job.report);
    end else if (rem_right) begin
      nxt_kind = KIND_RIGHT;
      nxt_last = ~head_job.report;
    end else begin
      nxt_kind = KIND_REPORT;
      nxt_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      done_r  <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
      if (load) begin
        if (nxt_last) begin
          done_r <= '0;
        end else if (nxt_kind == KIND_LEFT) begin
          done_r[0] <= 1'b1;
        end else begin
          done_r[1] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= nxt_kind;
      last_r <= nxt_last;
      if (nxt_kind == KIND_REPORT) begin
        lsum_r <= head_job.left_sum;
        rsum_r <= head_job.right_sum;
        span_r <= head_job.span;
      end else begin
        lsum_r <= '0;
        rsum_r <= '0;
        span_r <= '0;
      end
    end
  end

  assign out_valid      = valid_r;
  assign out_kind       = kind_r;
  assign out_left_sum   = lsum_r;
  assign out_right_sum  = rsum_r;
  assign out_span_ticks = span_r;
  assign out_last       = last_r;

endmodule

// File: hw/rtl/bumper_edge_and_wheel_click_accumulator_top.sv
// Bumper edge and wheel click accumulator. One input beat is taken per clock
// while in_stall is low; the front end updates switch history, saturating
// sums and the report deadline in that same cycle and queues a job for each
// beat that produces results. The back end sends one result beat per clock
// while out_stall is low, so a beat that causes k results (up to three: left
// press, right press, click report) sends them one after another. The first
// result is held in a queue slot, then in the back-end output register. The
// job queue has QUEUE_DEPTH entries; in_stall rises only while it is full.
// Configuration writes are always ready and take effect at the next report.
module bumper_edge_and_wheel_click_accumulator_top #(
  parameter int QUEUE_DEPTH = bewc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic [2:0]         in_switch_bits,
  input  logic signed [7:0]  in_left_delta,
  input  logic signed [7:0]  in_right_delta,
  input  logic [31:0]        in_packet_stamp,
  input  logic [31:0]        in_now_ticks,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic signed [15:0] out_left_sum,
  output logic signed [15:0] out_right_sum,
  output logic [15:0]        out_span_ticks,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_report_interval
);
  import bewc_pkg::*;

  q_stat_t q_stat;
  logic    q_push;
  job_t    q_job;
  job_t    head_job;
  logic    q_pop;

  bewc_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_switch_bits      (in_switch_bits),
    .in_left_delta       (in_left_delta),
    .in_right_delta      (in_right_delta),
    .in_packet_stamp     (in_packet_stamp),
    .in_now_ticks        (in_now_ticks),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_report_interval (cfg_report_interval),
    .q_stat              (q_stat),
    .q_push              (q_push),
    .q_job               (q_job)
  );

  bewc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  bewc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_job       (head_job),
    .q_stat         (q_stat),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_left_sum   (out_left_sum),
    .out_right_sum  (out_right_sum),
    .out_span_ticks (out_span_ticks),
    .out_last       (out_last)
  );

endmodule

// File: hw/rtl/bewc_checker.sv
`include "bumper_edge_and_wheel_click_accumulator_top_defines.svh"

module bewc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_kind,
  input logic signed [15:0] out_left_sum,
  input logic signed [15:0] out_right_sum,
  input logic [15:0]        out_span_ticks,
  input logic               out_last
);
  import bewc_pkg::*;

  // hold a stalled result beat
  `BEWC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `BEWC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_kind) && $stable(out_last))
  // a report always closes the results of its input beat
  `BEWC_ASSERT_SAME(a_report_last, out_valid && out_kind == KIND_REPORT, out_last)
  // press events carry no sums
  `BEWC_ASSERT_SAME(a_event_zero, out_valid && out_kind != KIND_REPORT, out_left_sum == 16'sd0 && out_right_sum == 16'sd0 && out_span_ticks == 16'd0)

endmodule

bind bumper_edge_and_wheel_click_accumulator_top bewc_checker u_bewc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_kind       (out_kind),
  .out_left_sum   (out_left_sum),
  .out_right_sum  (out_right_sum),
  .out_span_ticks (out_span_ticks),
  .out_last       (out_last)
);

// File: dv/tb_bumper_edge_and_wheel_click_accumulator_top.sv
`timescale 1ns / 1ps

module tb_bumper_edge_and_wheel_click_accumulator_top;
  import bewc_pkg::*;

  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] left_sum;
    logic signed [15:0] right_sum;
    logic [15:0]        span;
    logic               last;
  } click_result_t;

  // Tracks switch history, wheel sums and the report deadline, and holds
  // the result beats still owed by the block.
  class click_scoreboard;
    logic [15:0]        interval;
    logic [2:0]         prev_sw;
    logic signed [15:0] left_acc;
    logic signed [15:0] right_acc;
    logic [31:0]        latest_stamp;
    logic [31:0]        period_start;
    logic [31:0]        deadline;
    bit                 pending;
    click_result_t      owed_q[$];
    int                 errors;

    function new();
      interval     = REPORT_INTERVAL_RST;
      prev_sw      = '0;
      left_acc     = '0;
      right_acc    = '0;
      latest_stamp = '0;
      period_start = '0;
      deadline     = {16'd0, REPORT_INTERVAL_RST};
      pending      = 1'b0;
      errors       = 0;
    endfunction

    function void set_interval(logic [15:0] value);
      interval = value;
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction

    function logic signed [15:0] sat_add(logic signed [15:0] acc, logic signed [7:0] d);
      int s;
      s = int'(acc) + int'(d);
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      return s[15:0];
    endfunction

    function click_result_t press(logic [1:0] kind);
      click_result_t r;
      r.kind      = kind;
      r.left_sum  = '0;
      r.right_sum = '0;
      r.span      = '0;
      r.last      = 1'b0;
      return r;
    endfunction

    function void note_input(logic func, logic [2:0] sw, logic signed [7:0] ld,
                             logic signed [7:0] rd, logic [31:0] stamp, logic [31:0] now);
      click_result_t batch[$];
      click_result_t r;
      logic [2:0]    cur;
      logic [2:0]    rise;
      logic [31:0]   diff;
      if (func) begin
        cur     = sw & SWITCH_MASK;
        rise    = ~prev_sw & cur;
        prev_sw = cur;
        // left press goes out before right press
        if (rise[SWITCH_LEFT]) batch.push_back(press(KIND_LEFT));
        if (rise[SWITCH_RIGHT]) batch.push_back(press(KIND_RIGHT));
        left_acc     = sat_add(left_acc, ld);
        right_acc    = sat_add(right_acc, rd);
        latest_stamp = stamp;
        pending      = 1'b1;
      end
      if (pending && now >= deadline) begin
        diff        = latest_stamp - period_start;
        r.kind      = KIND_REPORT;
        r.left_sum  = left_acc;
        r.right_sum = right_acc;
        r.span      = diff[15:0];
        r.last      = 1'b0;
        batch.push_back(r);
        pending      = 1'b0;
        left_acc     = '0;
        right_acc    = '0;
        period_start = latest_stamp;
        deadline     = now + {16'd0, interval};
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) owed_q.push_back(batch[i]);
    endfunction

    function void check_result(logic [1:0] kind, logic signed [15:0] ls,
                               logic signed [15:0] rs, logic [15:0] span, logic last);
      click_result_t e;
      if (owed_q.size() == 0) begin
        $error("result beat with nothing expected: kind %0d", kind);
        errors++;
      end else begin
        e = owed_q.pop_front();
        if (kind !== e.kind) begin
          $error("kind mismatch: expected %0d, actual %0d", e.kind, kind);
          errors++;
        end
        if (ls !== e.left_sum) begin
          $error("left_sum mismatch: expected %0d, actual %0d", e.left_sum, ls);
          errors++;
        end
        if (rs !== e.right_sum) begin
          $error("right_sum mismatch: expected %0d, actual %0d", e.right_sum, rs);
          errors++;
        end
        if (span !== e.span) begin
          $error("span_ticks mismatch: expected %0d, actual %0d", e.span, span);
          errors++;
        end
        if (last !== e.last) begin
          $error("last mismatch: expected %0d, actual %0d", e.last, last);
          errors++;
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_func = 1'b0;
  logic [2:0]         in_switch_bits = '0;
  logic signed [7:0]  in_left_delta = '0;
  logic signed [7:0]  in_right_delta = '0;
  logic [31:0]        in_packet_stamp = '0;
  logic [31:0]        in_now_ticks = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_kind;
  logic signed [15:0] out_left_sum;
  logic signed [15:0] out_right_sum;
  logic [15:0]        out_span_ticks;
  logic               out_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        cfg_report_interval = '0;

  click_scoreboard sb = new();
  logic [31:0]     tb_now;
  bit              tx_quiet = 1'b0;
  bit              rx_quiet = 1'b0;
  int              stall_left = 0;
  int              stall_pick;

  bumper_edge_and_wheel_click_accumulator_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_switch_bits      (in_switch_bits),
    .in_left_delta       (in_left_delta),
    .in_right_delta      (in_right_delta),
    .in_packet_stamp     (in_packet_stamp),
    .in_now_ticks        (in_now_ticks),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_left_sum        (out_left_sum),
    .out_right_sum       (out_right_sum),
    .out_span_ticks      (out_span_ticks),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_report_interval (cfg_report_interval)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver backpressure: mostly open, short stalls, now and then a long one.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_pick = $urandom_range(0, 99);
      if (rx_quiet || stall_pick < 60) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(1, 12);
      end else if (stall_pick < 93) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(1, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(10, 40);
      end
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_input(in_func, in_switch_bits, in_left_delta, in_right_delta,
                      in_packet_stamp, in_now_ticks);
      if (out_valid && !out_stall)
        sb.check_result(out_kind, out_left_sum, out_right_sum, out_span_ticks, out_last);
    end
  end

  // Present one beat and hold it until taken; valid stays high on return.
  task automatic send_item(logic func, logic [2:0] sw, logic [7:0] ld, logic [7:0] rd,
                           logic [31:0] stamp, logic [31:0] now);
    in_valid        <= 1'b1;
    in_func         <= func;
    in_switch_bits  <= sw;
    in_left_delta   <= ld;
    in_right_delta  <= rd;
    in_packet_stamp <= stamp;
    in_now_ticks    <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_gap();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (tx_quiet || pick < 65) len = 0;
    else if (pick < 93) len = $urandom_range(1, 3);
    else len = $urandom_range(10, 40);
    if (len > 0) begin
      in_valid <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // Drop valid and hold off until every owed result has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_interval(logic [15:0] value);
    cfg_valid           <= 1'b1;
    cfg_report_interval <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_interval(value);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int count, bit saturate, int noise_pct);
    logic        func;
    logic [2:0]  sw;
    logic [7:0]  ld;
    logic [7:0]  rd;
    logic [31:0] stamp;
    logic [31:0] now;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (saturate || pick < 90) tb_now = tb_now + $urandom_range(0, 4);
      else if (pick < 97) tb_now = tb_now + $urandom_range(50, 400);
      else tb_now = $urandom();
      now = tb_now;
      if ($urandom_range(0, 99) < noise_pct) now = $urandom();
      sw = 3'($urandom_range(0, 7));
      if (saturate) begin
        // push left toward +max and right toward -max
        func = 1'b1;
        ld   = 8'($urandom_range(122, 127));
        rd   = 8'($urandom_range(128, 134));
      end else begin
        func = ($urandom_range(0, 99) < 75);
        ld   = 8'($urandom());
        rd   = 8'($urandom());
      end
      stamp = ($urandom_range(0, 99) < 80) ? tb_now - $urandom_range(0, 3) : $urandom();
      send_item(func, sw, ld, rd, stamp, now);
      idle_gap();
      if ($urandom_range(0, 199) == 0) wait_idle();
      if (saturate && i == count / 2) begin
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset interval of 100, first deadline at 100
    send_item(1'b0, 3'b000, 8'h00, 8'h00, 32'd0, 32'd0);
    send_item(1'b1, 3'b010, 8'h7f, 8'h80, 32'd5, 32'd5);
    idle_gap();
    send_item(1'b1, 3'b011, 8'h80, 8'h7f, 32'd10, 32'd10);
    send_item(1'b1, 3'b100, 8'h01, 8'hff, 32'd20, 32'd20);
    idle_gap();
    send_item(1'b1, 3'b111, 8'h00, 8'h00, 32'd30, 32'd30);
    send_item(1'b1, 3'b000, 8'h00, 8'h00, 32'd99, 32'd99);
    // tick only: junk in the packet fields must be ignored
    send_item(1'b0, 3'b111, 8'h55, 8'haa, 32'hdead_beef, 32'd100);
    idle_gap();
    send_item(1'b0, 3'b000, 8'h00, 8'h00, 32'd0, 32'd300);
    send_item(1'b1, 3'b011, 8'h7f, 8'h80, 32'd300, 32'd300);
    wait_idle();

    write_interval(16'd0);
    send_item(1'b1, 3'b000, 8'h01, 8'h01, 32'd400, 32'd400);
    send_item(1'b1, 3'b000, 8'hff, 8'hff, 32'd400, 32'd400);
    send_item(1'b0, 3'b000, 8'h00, 8'h00, 32'd0, 32'd400);
    wait_idle();

    write_interval(16'hffff);
    send_item(1'b1, 3'b001, 8'h10, 8'hf0, 32'd401, 32'd401);
    send_item(1'b1, 3'b000, 8'h7f, 8'h7f, 32'hffff_fff0, 32'hffff_ff00);
    idle_gap();
    send_item(1'b1, 3'b110, 8'h80, 8'h80, 32'hffff_ffff, 32'hffff_ffff);
    send_item(1'b1, 3'b000, 8'h00, 8'h00, 32'd0, 32'd0);
    send_item(1'b0, 3'b000, 8'h00, 8'h00, 32'd0, 32'h0000_fffe);
    wait_idle();

    write_interval(16'd1);
    tb_now = 32'h0000_fff0;
    run_random(50, 1'b0, 0);
    wait_idle();

    // long period with small time steps so both sums hit their limits
    write_interval(16'hffff);
    tb_now   = 32'h0010_0000;
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    run_random(280, 1'b1, 0);
    send_item(1'b0, 3'b000, 8'h00, 8'h00, 32'd0, 32'hffff_ffff);
    wait_idle();

    write_interval(16'd0);
    tb_now = 32'h0001_0000;
    run_random(30, 1'b0, 0);
    wait_idle();

    write_interval(16'($urandom_range(1, 300)));
    tb_now = 32'hffff_ff00;
    run_random(60, 1'b0, 10);
    wait_idle();

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/bewc_pkg.sv
hw/rtl/bewc_front.sv
hw/rtl/bewc_queue.sv
hw/rtl/bewc_back.sv
hw/rtl/bumper_edge_and_wheel_click_accumulator_top.sv
hw/rtl/bewc_checker.sv
dv/tb_bumper_edge_and_wheel_click_accumulator_top.sv
